@@ rtl/tea_pkg.sv @@
// tea_pkg: shared types, constants and the half-round mixing function
// for the tea block cipher pipeline
// depends on: nothing
package tea_pkg;

  localparam int WORD_W   = 32;
  localparam int ROUNDS   = 32;
  localparam int STAGES   = 2 * ROUNDS;
  localparam int NUM_KEYS = 4;
  localparam int CFG_IDX_W = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;

  // operation codes
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 8'd3;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_set_t;

  // one tea half update term, all modulo 2^32
  function automatic word_t mix_half(input word_t h, input word_t sum,
                                     input word_t ka, input word_t kb);
    mix_half = ((h << 4) + ka) ^ (h + sum) ^ ((h >> 5) + kb);
  endfunction

endpackage

@@ rtl/tea_in_if.sv @@
// tea_in_if: input block channel with valid/ready handshake
// depends on: tea_pkg
interface tea_in_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  op_t   operation;
  word_t block_left;
  word_t block_right;

  modport source (output valid, output operation, output block_left,
                  output block_right, input ready);
  modport sink   (input valid, input operation, input block_left,
                  input block_right, output ready);
endinterface

@@ rtl/tea_out_if.sv @@
// tea_out_if: result block channel with valid/ready handshake
// depends on: tea_pkg
interface tea_out_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  word_t result_left;
  word_t result_right;

  modport source (output valid, output result_left, output result_right,
                  input ready);
  modport sink   (input valid, input result_left, input result_right,
                  output ready);
endinterface

@@ rtl/tea_cfg_if.sv @@
// tea_cfg_if: configuration write channel, register index plus data
// depends on: tea_pkg
interface tea_cfg_if;
  import tea_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  word_t                wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ rtl/tea_key_regs.sv @@
// tea_key_regs: the four 32-bit key words written over the config channel
// depends on: tea_pkg, tea_cfg_if
module tea_key_regs (
  input  logic              clk,
  input  logic              rst_n,
  tea_cfg_if.sink           cfg,
  output tea_pkg::key_set_t keys
);
  import tea_pkg::*;

  key_set_t keys_r;
  key_set_t keys_nxt;

  // writes are always accepted, ready is tied high
  assign cfg.ready = 1'b1;

  // decode index, unknown indexes are dropped
  always_comb begin
    keys_nxt = keys_r;
    if (cfg.valid) begin
      case (cfg.reg_index)
        REG_KEY_WORD0: keys_nxt.k0 = cfg.wr_data;
        REG_KEY_WORD1: keys_nxt.k1 = cfg.wr_data;
        REG_KEY_WORD2: keys_nxt.k2 = cfg.wr_data;
        REG_KEY_WORD3: keys_nxt.k3 = cfg.wr_data;
        default:       keys_nxt = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;
endmodule

@@ rtl/tea_pipe.sv @@
// tea_pipe: unrolled tea datapath, one register stage per half round
// depends on: tea_pkg
module tea_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  tea_pkg::op_t      in_op,
  input  tea_pkg::word_t    in_left,
  input  tea_pkg::word_t    in_right,
  input  tea_pkg::key_set_t keys,
  output logic              out_valid,
  output tea_pkg::word_t    out_left,
  output tea_pkg::word_t    out_right
);
  import tea_pkg::*;

  logic  valid_r [STAGES];
  op_t   op_r    [STAGES];
  word_t left_r  [STAGES];
  word_t right_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int RND = s / 2;
    localparam word_t SUM_ENC = 32'(DELTA * (RND + 1));
    localparam word_t SUM_DEC = 32'(DELTA * (ROUNDS - RND));

    logic  v_in;
    op_t   op_in;
    word_t l_in;
    word_t r_in;
    word_t sum;
    word_t l_nxt;
    word_t r_nxt;

    // previous stage, or the accepted input word
    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign op_in = in_op;
      assign l_in  = in_left;
      assign r_in  = in_right;
    end else begin : g_rest
      assign v_in  = valid_r[s-1];
      assign op_in = op_r[s-1];
      assign l_in  = left_r[s-1];
      assign r_in  = right_r[s-1];
    end

    assign sum = (op_in == OP_DECRYPT) ? SUM_DEC : SUM_ENC;

    // first half of a round: encrypt updates left, decrypt undoes right;
    // second half: encrypt updates right, decrypt undoes left
    if (s % 2 == 0) begin : g_half_a
      always_comb begin
        l_nxt = l_in;
        r_nxt = r_in;
        if (op_in == OP_DECRYPT) begin
          r_nxt = r_in - mix_half(l_in, sum, keys.k2, keys.k3);
        end else begin
          l_nxt = l_in + mix_half(r_in, sum, keys.k0, keys.k1);
        end
      end
    end else begin : g_half_b
      always_comb begin
        l_nxt = l_in;
        r_nxt = r_in;
        if (op_in == OP_DECRYPT) begin
          l_nxt = l_in - mix_half(r_in, sum, keys.k0, keys.k1);
        end else begin
          r_nxt = r_in + mix_half(l_in, sum, keys.k2, keys.k3);
        end
      end
    end

    // stage valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (en) begin
        op_r[s]    <= op_in;
        left_r[s]  <= l_nxt;
        right_r[s] <= r_nxt;
      end
    end
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_left  = left_r[STAGES-1];
  assign out_right = right_r[STAGES-1];
endmodule

@@ rtl/tea_out_buf.sv @@
// tea_out_buf: output register plus one skid entry behind the pipeline
// depends on: tea_pkg, tea_out_if
module tea_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pipe_valid,
  input  tea_pkg::word_t pipe_left,
  input  tea_pkg::word_t pipe_right,
  output logic           pipe_en,
  tea_out_if.source      out
);
  import tea_pkg::*;

  logic  out_valid_r, out_valid_nxt;
  word_t out_left_r, out_right_r;
  logic  skid_valid_r, skid_valid_nxt;
  word_t skid_left_r, skid_right_r;
  logic  take;
  logic  out_load_pipe;
  logic  out_load_skid;
  logic  skid_load;

  // pipeline moves only while the skid entry is free
  assign pipe_en = !skid_valid_r;
  assign take    = out_valid_r && out.ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load_pipe  = 1'b0;
    out_load_skid  = 1'b0;
    skid_load      = 1'b0;
    if (skid_valid_r) begin
      if (take) begin
        out_load_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_valid_r || take) begin
        out_load_pipe = 1'b1;
        out_valid_nxt = 1'b1;
      end else begin
        skid_load      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_load_pipe) begin
      out_left_r  <= pipe_left;
      out_right_r <= pipe_right;
    end else if (out_load_skid) begin
      out_left_r  <= skid_left_r;
      out_right_r <= skid_right_r;
    end
    if (skid_load) begin
      skid_left_r  <= pipe_left;
      skid_right_r <= pipe_right;
    end
  end

  assign out.valid        = out_valid_r;
  assign out.result_left  = out_left_r;
  assign out.result_right = out_right_r;
endmodule

@@ rtl/tea_block_cipher.sv @@
// tea_block_cipher: top level of the pipelined tea block cipher
// depends on: tea_pkg, tea_in_if, tea_out_if, tea_cfg_if, tea_key_regs,
//   tea_pipe, tea_out_buf

// TEA cipher on one 64-bit block per word under a 128-bit key held in four
// config registers (index 0..3, other indexes ignored). Each round is split
// into two half-round register stages, so a block passes 64 stages, the
// first loaded at the accepting edge, and then the output register; one
// block is accepted every cycle while the result side keeps up. The output
// register is backed by one skid entry; the pipeline halts as a whole only
// while that entry is full, and in_ch.ready is then low. Keys are read live
// by every stage, so write them only while no block is in flight.
module tea_block_cipher (
  input  logic      clk,
  input  logic      rst_n,
  tea_in_if.sink    in_ch,
  tea_out_if.source out_ch,
  tea_cfg_if.sink   cfg_ch
);
  import tea_pkg::*;

  key_set_t keys;
  logic     pipe_en;
  logic     pipe_valid;
  word_t    pipe_left;
  word_t    pipe_right;

  // key registers
  tea_key_regs u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .keys  (keys)
  );

  // input accepted whenever the pipeline advances
  assign in_ch.ready = pipe_en;

  tea_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_left   (in_ch.block_left),
    .in_right  (in_ch.block_right),
    .keys      (keys),
    .out_valid (pipe_valid),
    .out_left  (pipe_left),
    .out_right (pipe_right)
  );

  tea_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (pipe_valid),
    .pipe_left  (pipe_left),
    .pipe_right (pipe_right),
    .pipe_en    (pipe_en),
    .out        (out_ch)
  );

  // a stalled pipeline means a result is waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("pipeline stalled with no result pending");

  // taking the result frees the skid entry on the next cycle
  a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !in_ch.ready) |=> in_ch.ready)
    else $error("skid entry not drained after output taken");

  // a key word write lands in its register
  a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready && cfg_ch.reg_index == REG_KEY_WORD0)
    |=> keys.k0 == $past(cfg_ch.wr_data))
    else $error("key word 0 write lost");
endmodule

@@ bench/tb_tea_block_cipher.sv @@
// tb_tea_block_cipher: self-checking bench for the pipelined tea cipher,
// random key sets and blocks, round trips, stalls on both channels
// depends on: tea_pkg, tea_in_if, tea_out_if, tea_cfg_if, tea_block_cipher
module tb_tea_block_cipher;
  import tea_pkg::*;

  typedef struct packed {
    word_t left;
    word_t right;
  } half_pair_t;

  // tracks the key, predicts each block and checks the result words in order
  class tea_scoreboard;
    key_set_t   key;
    half_pair_t pending_blocks[$];
    int         mismatches;

    function new();
      key = '0;
      mismatches = 0;
    endfunction

    function void set_key(logic [CFG_IDX_W-1:0] idx, word_t data);
      case (idx)
        REG_KEY_WORD0: key.k0 = data;
        REG_KEY_WORD1: key.k1 = data;
        REG_KEY_WORD2: key.k2 = data;
        REG_KEY_WORD3: key.k3 = data;
        default: ;
      endcase
    endfunction

    // one half update term: shifted, keyed and summed parts xored together
    function word_t round_term(word_t h, word_t sum, word_t ka, word_t kb);
      return ((h << 4) + ka) ^ (h + sum) ^ ((h >> 5) + kb);
    endfunction

    function half_pair_t tea_transform(op_t op, word_t left, word_t right);
      word_t      sum;
      half_pair_t res;
      if (op == OP_ENCRYPT) begin
        sum = '0;
        for (int i = 0; i < ROUNDS; i++) begin
          sum   = sum + DELTA;
          left  = left + round_term(right, sum, key.k0, key.k1);
          right = right + round_term(left, sum, key.k2, key.k3);
        end
      end else begin
        sum = word_t'(ROUNDS * DELTA);
        for (int i = 0; i < ROUNDS; i++) begin
          right = right - round_term(left, sum, key.k2, key.k3);
          left  = left - round_term(right, sum, key.k0, key.k1);
          sum   = sum - DELTA;
        end
      end
      res.left  = left;
      res.right = right;
      return res;
    endfunction

    function half_pair_t note_block(op_t op, word_t left, word_t right);
      half_pair_t res;
      res = tea_transform(op, left, right);
      pending_blocks.push_back(res);
      return res;
    endfunction

    function int pending();
      return pending_blocks.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_block(word_t left, word_t right);
      half_pair_t want;
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("result %h %h with nothing outstanding", left, right));
      end else begin
        want = pending_blocks.pop_front();
        if (left !== want.left)
          report_mismatch($sformatf("result_left %h, predicted %h", left, want.left));
        if (right !== want.right)
          report_mismatch($sformatf("result_right %h, predicted %h", right, want.right));
      end
    endtask
  endclass

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int END_CYCLES       = 100;
  localparam int RANDOM_PER_PHASE = 322;
  localparam int RECENT_DEPTH     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_KEY_WORD3 + 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  logic clk = 1'b0;
  logic rst_n;

  tea_in_if  in_if();
  tea_out_if out_if();
  tea_cfg_if cfg_if();

  tea_scoreboard sb;
  half_pair_t    recent_cipher[$];
  logic          tx_calm = 1'b0;
  logic          rx_calm = 1'b0;
  int            stall_left = 0;
  int            cycle_count = 0;

  tea_block_cipher dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side ready with random stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (rx_calm || $urandom_range(0, 99) < 75) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 70) ? $urandom_range(0, 2) :
                                                   $urandom_range(10, 50);
    end
  end

  // result word check
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_block(out_if.result_left, out_if.result_right);
  end

  // drive one block word and hold it until accepted; valid stays high
  task automatic send_block(op_t op, word_t left, word_t right, output half_pair_t res);
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.block_left  <= left;
    in_if.block_right <= right;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = sb.note_block(op, left, right);
    if (op == OP_ENCRYPT) begin
      recent_cipher.push_back(res);
      if (recent_cipher.size() > RECENT_DEPTH) void'(recent_cipher.pop_front());
    end
  endtask

  task automatic idle_input();
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain(int extra);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_key(idx, data);
  endtask

  // new key while idle, with writes to unused indexes around it
  task automatic load_keys(key_set_t ks);
    drain(DRAIN_CYCLES);
    write_reg(REG_UNUSED_LO, $urandom());
    write_reg(REG_KEY_WORD0, ks.k0);
    write_reg(REG_KEY_WORD1, ks.k1);
    write_reg(REG_KEY_WORD2, ks.k2);
    write_reg(REG_KEY_WORD3, ks.k3);
    write_reg(REG_UNUSED_HI, $urandom());
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t edge_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // corner blocks in both directions, plus one encrypt/decrypt round trip
  task automatic run_directed();
    word_t      corners[3] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001};
    half_pair_t res;
    for (int o = 0; o < 2; o++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          send_block(op_t'(o), corners[a], corners[b], res);
          idle_input();
        end
      end
    end
    send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, res);
    send_block(OP_DECRYPT, res.left, res.right, res);
  endtask

  // random blocks, about a quarter of them decrypting recent ciphertexts
  task automatic run_random(int count);
    int         sel;
    op_t        op;
    word_t      left;
    word_t      right;
    half_pair_t pick;
    half_pair_t res;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = tx_calm;
      end
      sel = $urandom_range(0, 99);
      if (sel < 25 && recent_cipher.size() != 0) begin
        pick  = recent_cipher[$urandom_range(0, recent_cipher.size() - 1)];
        op    = OP_DECRYPT;
        left  = pick.left;
        right = pick.right;
      end else if (sel < 35) begin
        op    = op_t'($urandom_range(0, 1));
        left  = edge_word();
        right = edge_word();
      end else begin
        op    = op_t'($urandom_range(0, 1));
        left  = $urandom();
        right = $urandom();
      end
      send_block(op, left, right, res);
      idle_input();
    end
  endtask

  // main sequence
  initial begin
    key_set_t ks;
    sb = new();
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_ENCRYPT;
    in_if.block_left  = '0;
    in_if.block_right = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = '0;
    cfg_if.wr_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of all zeros
    run_directed();
    idle_input();
    run_random(RANDOM_PER_PHASE);

    ks = {4{32'hFFFF_FFFF}};
    load_keys(ks);
    run_random(RANDOM_PER_PHASE);

    ks = {$urandom(), $urandom(), $urandom(), $urandom()};
    load_keys(ks);
    run_random(RANDOM_PER_PHASE / 2);
    // sender holds off until the pipeline is empty
    drain(0);
    run_random(RANDOM_PER_PHASE / 2);

    ks = {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    load_keys(ks);
    run_random(RANDOM_PER_PHASE);

    ks = {$urandom(), $urandom(), $urandom(), $urandom()};
    load_keys(ks);
    run_random(RANDOM_PER_PHASE);

    ks = '0;
    load_keys(ks);
    run_random(RANDOM_PER_PHASE);

    // wait out the tail and look for extra results
    rx_calm = 1'b0;
    drain(END_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
